FILE: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

FILE: hdl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned WordW   = 24;
  localparam int unsigned AccW    = 18;

  localparam logic [CharW-1:0] PadChar = 8'h3D;

  // one decoded group waiting to be serialized
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [1:0]       count;  // bytes to emit, 1 to 3
    logic             fin;    // group closes the stream
  } grp_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hdl/base64_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Base64 character stream to byte stream decoder.
// ----------------------------------------------------------------------------
// The decoder takes one character per cycle while its group queue has room
// and gives out at most one byte per cycle. A full group of four characters
// yields three bytes, so ordinary streams run at one character per cycle; a
// final partial group yields three bytes from one character, so the
// single-byte output register is what limits throughput there. The front
// stage writes each completed group into a QueueDepth entry queue and the
// back stage loads its bytes into the output register.
module base64_stream_decoder_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code_i,
  input  logic       end_of_input_i,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte_o,
  output logic       last_of_group_o,
  output logic       last_of_stream_o
);

  logic              push, pop;
  b64d_pkg::grp_t    push_grp, head_grp;
  b64d_pkg::q_stat_t q_stat;

  // character intake and group assembly
  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_grp_o     (push_grp)
  );

  // group queue
  b64d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .pop_i      (pop),
    .head_o     (head_grp),
    .stat_o     (q_stat)
  );

  // byte output
  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_grp),
    .q_stat_i         (q_stat),
    .pop_o            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .data_byte_o      (data_byte_o),
    .last_of_group_o  (last_of_group_o),
    .last_of_stream_o (last_of_stream_o)
  );

endmodule

FILE: hdl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets, gathers groups of four and
// pushes each group, full or closed early by end of input, into the queue.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [b64d_pkg::CharW-1:0]      char_code_i,
  input  logic                            end_of_input_i,
  input  b64d_pkg::q_stat_t               q_stat_i,
  output logic                            push_o,
  output b64d_pkg::grp_t                  push_grp_o
);

  logic [1:0]                    pos_q, pos_d;
  logic [b64d_pkg::AccW-1:0]     acc_q, acc_d;
  logic                          pad3_q, pad3_d;
  logic [b64d_pkg::SextetW-1:0]  sext;
  logic [b64d_pkg::AccW-1:0]     acc_shift;
  logic                          is_pad;
  logic                          accept;

  // character to sextet
  always_comb begin
    sext = '0;
    if (char_code_i >= 8'h41 && char_code_i <= 8'h5A) begin
      sext = 6'(char_code_i - 8'h41);
    end else if (char_code_i >= 8'h61 && char_code_i <= 8'h7A) begin
      sext = 6'(char_code_i - 8'h61 + 8'd26);
    end else if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      sext = 6'(char_code_i - 8'h30 + 8'd52);
    end else if (char_code_i == 8'h2B) begin
      sext = 6'd62;
    end else if (char_code_i == 8'h2F) begin
      sext = 6'd63;
    end
  end

  assign is_pad    = (char_code_i == b64d_pkg::PadChar);
  assign acc_shift = {acc_q[b64d_pkg::AccW-b64d_pkg::SextetW-1:0], sext};
  assign in_stall  = q_stat_i.full;
  assign accept    = in_valid && !in_stall;

  // group assembly and push decision
  always_comb begin
    pos_d  = pos_q;
    acc_d  = acc_q;
    pad3_d = pad3_q;
    push_o = 1'b0;
    push_grp_o.fin   = end_of_input_i;
    push_grp_o.count = 2'd3;
    case (pos_q)
      2'd0:    push_grp_o.word = {sext, 18'b0};
      2'd1:    push_grp_o.word = {acc_q[5:0], sext, 12'b0};
      2'd2:    push_grp_o.word = {acc_q[11:0], sext, 6'b0};
      2'd3: begin
        push_grp_o.word  = {acc_q, sext};
        push_grp_o.count = 2'd3 - 2'(end_of_input_i && is_pad)
                                - 2'(end_of_input_i && pad3_q);
      end
      default: push_grp_o.word = '0;
    endcase
    if (accept) begin
      push_o = (pos_q == 2'd3) || end_of_input_i;
      if (push_o) begin
        pos_d  = '0;
        acc_d  = '0;
        pad3_d = 1'b0;
      end else begin
        pos_d = pos_q + 2'd1;
        acc_d = acc_shift;
        if (pos_q == 2'd2) begin
          pad3_d = is_pad;
        end
      end
    end
  end

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      acc_q  <= '0;
      pad3_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      pad3_q <= pad3_d;
    end
  end

endmodule

FILE: hdl/b64d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of decoded groups between front and back.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64d_pkg::grp_t    push_grp_i,
  input  logic              pop_i,
  output b64d_pkg::grp_t    head_o,
  output b64d_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_pkg::grp_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Serializes queued groups into bytes, one byte per cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64d_pkg::grp_t    head_i,
  input  b64d_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_byte_o,
  output logic              last_of_group_o,
  output logic              last_of_stream_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       lgrp_q, lgrp_d;
  logic       lstr_q, lstr_d;
  logic       advance;
  logic       is_last;

  assign advance = !vld_q || !out_stall;
  assign is_last = (idx_q == head_i.count - 2'd1);

  // byte selection and index stepping
  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    lgrp_d = lgrp_q;
    lstr_d = lstr_q;
    pop_o  = 1'b0;
    if (advance) begin
      vld_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        case (idx_q)
          2'd0:    byte_d = head_i.word[23:16];
          2'd1:    byte_d = head_i.word[15:8];
          2'd2:    byte_d = head_i.word[7:0];
          default: byte_d = '0;
        endcase
        lgrp_d = is_last;
        lstr_d = is_last && head_i.fin;
        if (is_last) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    lgrp_q <= lgrp_d;
    lstr_q <= lstr_d;
  end

  assign out_valid        = vld_q;
  assign data_byte_o      = byte_q;
  assign last_of_group_o  = lgrp_q;
  assign last_of_stream_o = lstr_q;

endmodule

FILE: hdl/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_byte_o,
  input logic       last_of_group_o,
  input logic       last_of_stream_o
);

  logic [1:0] run_q;
  logic       out_acc;

  assign out_acc = out_valid && !out_stall;

  // bytes taken since the last end of group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_acc) begin
      run_q <= last_of_group_o ? 2'd0 : 2'(run_q + 2'd1);
    end
  end

  `ASSERT_NEVER(a_stream_end_closes_group, clk_i, rst_ni, out_valid && last_of_stream_o && !last_of_group_o)
  `ASSERT_NEVER(a_group_at_most_three, clk_i, rst_ni, out_valid && !last_of_group_o && run_q == 2'd2)
  `ASSERT_CLK(a_valid_holds, clk_i, rst_ni, out_valid && out_stall |=> out_valid)
  `ASSERT_CLK(a_payload_holds, clk_i, rst_ni, out_valid && out_stall |=> $stable(data_byte_o) && $stable(last_of_group_o) && $stable(last_of_stream_o))

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .data_byte_o      (data_byte_o),
  .last_of_group_o  (last_of_group_o),
  .last_of_stream_o (last_of_stream_o)
);

FILE: tb/tb_base64_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_core
// Self-checking bench for the base64 stream decoder. A short table of
// directed characters comes first: some rows carry the bytes they must give,
// and the rest rely on the decode predictor. Random streams follow, mostly
// well-formed groups with random padding and partial final groups, and some
// raw noise bytes. Every output byte is compared with the predicted byte
// queue; both sides idle at random until the last phase of the run.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_core;

  localparam int RandItems = 300;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;

  // one predicted output byte
  typedef struct packed {
    logic [7:0] data;
    logic       grp_last;
    logic       strm_last;
  } out_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code_i = '0;
  logic       end_of_input_i = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte_o;
  logic       last_of_group_o;
  logic       last_of_stream_o;

  base64_stream_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code_i     (char_code_i),
    .end_of_input_i  (end_of_input_i),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_byte_o     (data_byte_o),
    .last_of_group_o (last_of_group_o),
    .last_of_stream_o(last_of_stream_o)
  );

  // character stream and the typed expectations of the directed rows
  logic [7:0]  char_list[$];
  logic        fin_list[$];
  logic        row_typed[$];
  int          row_count[$];
  logic [23:0] row_bytes[$];
  int          n_dir;
  int          n_items;

  // decoder state as predicted
  logic [1:0]  grp_pos;
  logic [17:0] held_sextets;
  logic        third_pad;
  out_byte_t   pending_bytes[$];
  out_byte_t   last_group[3];

  int send_idx;
  int n_in;
  int n_fail;
  int quiet_cycles;
  int sender_idle_pct;
  int receiver_stall_pct;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ascii to six-bit value, anything outside the alphabet is zero
  function automatic logic [5:0] sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  // six-bit value to its alphabet character
  function automatic logic [7:0] b64_char(input int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  task automatic add_char(input logic [7:0] c, input logic fin);
    char_list.push_back(c);
    fin_list.push_back(fin);
    row_typed.push_back(1'b0);
    row_count.push_back(0);
    row_bytes.push_back('0);
  endtask

  task automatic add_typed(input logic [7:0] c, input logic fin, input int n,
                           input logic [23:0] bytes);
    add_char(c, fin);
    row_typed[row_typed.size()-1] = 1'b1;
    row_count[row_count.size()-1] = n;
    row_bytes[row_bytes.size()-1] = bytes;
  endtask

  // decode one accepted character, queue the bytes it yields
  task automatic decode_char(input logic [7:0] c, input logic fin, output int n_out);
    logic [5:0]  v;
    logic [23:0] word;
    v = sextet_value(c);
    n_out = 0;
    word = '0;
    if (grp_pos != 2'd3) begin
      held_sextets = {held_sextets[11:0], v};
      if (grp_pos == 2'd2) third_pad = (c == b64d_pkg::PadChar);
      grp_pos = grp_pos + 2'd1;
      // partial final group is padded with zero sextets
      if (fin) begin
        word = 24'(held_sextets) << (6 * (4 - int'(grp_pos)));
        n_out = 3;
      end
    end else begin
      word = {held_sextets, v};
      n_out = 3;
      if (fin) begin
        if (c == b64d_pkg::PadChar) n_out--;
        if (third_pad) n_out--;
      end
    end
    for (int k = 0; k < n_out; k++) begin
      last_group[k].data = word[23-8*k -: 8];
      last_group[k].grp_last = (k == n_out - 1);
      last_group[k].strm_last = (k == n_out - 1) && fin;
      pending_bytes.push_back(last_group[k]);
    end
    if (n_out != 0) begin
      grp_pos = '0;
      held_sextets = '0;
      third_pad = 1'b0;
    end
  endtask

  // stimulus build: directed table, then random streams
  initial begin
    int kind;
    int n_grp;
    int style;
    int n_part;
    logic [7:0] c;
    // junk bytes and a mid-stream pad decode as zero
    add_typed(8'hFF, 1'b0, 0, 24'h0);
    add_typed(8'h00, 1'b0, 0, 24'h0);
    add_typed(b64d_pkg::PadChar, 1'b0, 0, 24'h0);
    add_typed("+", 1'b0, 3, 24'h00003E);
    // all ones, final full group
    add_typed("/", 1'b0, 0, 24'h0);
    add_typed("/", 1'b0, 0, 24'h0);
    add_typed("/", 1'b0, 0, 24'h0);
    add_typed("/", 1'b1, 3, 24'hFFFFFF);
    // final group with two pads
    add_typed("T", 1'b0, 0, 24'h0);
    add_typed("Q", 1'b0, 0, 24'h0);
    add_typed(b64d_pkg::PadChar, 1'b0, 0, 24'h0);
    add_typed(b64d_pkg::PadChar, 1'b1, 1, 24'h4D0000);
    // final group with one pad
    add_typed("T", 1'b0, 0, 24'h0);
    add_typed("W", 1'b0, 0, 24'h0);
    add_typed("E", 1'b0, 0, 24'h0);
    add_typed(b64d_pkg::PadChar, 1'b1, 2, 24'h4D6100);
    // pad in third place only
    add_char("a", 1'b0);
    add_char("0", 1'b0);
    add_char(b64d_pkg::PadChar, 1'b0);
    add_char("9", 1'b1);
    // partial final groups of one, two and three characters
    add_char("z", 1'b1);
    add_char("b", 1'b0);
    add_char("8", 1'b1);
    add_char("A", 1'b0);
    add_char("Z", 1'b0);
    add_char("1", 1'b1);
    n_dir = char_list.size();

    while (char_list.size() < n_dir + RandItems) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        // well-formed stream, random padding on the final group
        n_grp = $urandom_range(1, 4);
        style = $urandom_range(3);
        for (int g = 0; g < n_grp; g++) begin
          for (int i = 0; i < 4; i++) begin
            c = b64_char($urandom_range(63));
            if (g == n_grp - 1) begin
              if (i == 3 && (style == 1 || style == 2)) c = b64d_pkg::PadChar;
              if (i == 2 && (style == 2 || style == 3)) c = b64d_pkg::PadChar;
            end
            add_char(c, (g == n_grp - 1) && (i == 3));
          end
        end
      end else if (kind < 80) begin
        // stream ending in a partial group
        n_grp = $urandom_range(0, 2);
        n_part = $urandom_range(1, 3);
        for (int i = 0; i < 4 * n_grp + n_part; i++)
          add_char(b64_char($urandom_range(63)), i == 4 * n_grp + n_part - 1);
      end else begin
        // raw noise bytes with a stray end flag now and then
        n_part = $urandom_range(1, 8);
        for (int i = 0; i < n_part; i++)
          add_char(8'($urandom_range(255)), $urandom_range(5) == 0);
      end
    end
    n_items = char_list.size();
  end

  // sender side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) send_idx++;
      if (!(in_valid && in_stall)) begin
        if (send_idx < n_items && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          char_code_i <= char_list[send_idx];
          end_of_input_i <= fin_list[send_idx];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // accepted characters feed the predictor
  always @(posedge clk_i) begin
    int n_out;
    if (rst_ni && in_valid && !in_stall) begin
      decode_char(char_code_i, end_of_input_i, n_out);
      if (n_in < n_dir && row_typed[n_in]) begin
        if (n_out != row_count[n_in]) begin
          $display("%0t: row %0d byte count expected %0d got %0d", $time, n_in,
                   row_count[n_in], n_out);
          n_fail++;
        end else begin
          for (int k = 0; k < n_out; k++)
            if (last_group[k].data != row_bytes[n_in][23-8*k -: 8]) begin
              $display("%0t: row %0d byte %0d expected %h got %h", $time, n_in, k,
                       row_bytes[n_in][23-8*k -: 8], last_group[k].data);
              n_fail++;
            end
        end
      end
      n_in++;
    end
    // idle mix by phase of the run
    if (n_in < n_dir + RandItems / 3) begin
      sender_idle_pct <= 30;
      receiver_stall_pct <= 45;
    end else if (n_in < n_dir + 2 * RandItems / 3) begin
      sender_idle_pct <= 45;
      receiver_stall_pct <= 30;
    end else begin
      sender_idle_pct <= 0;
      receiver_stall_pct <= 0;
    end
  end

  // receiver side and byte check
  always @(posedge clk_i) begin
    out_byte_t exp_byte;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: data_byte expected none got %h", $time, data_byte_o);
        n_fail++;
      end else begin
        exp_byte = pending_bytes.pop_front();
        if (data_byte_o !== exp_byte.data) begin
          $display("%0t: data_byte expected %h got %h", $time, exp_byte.data,
                   data_byte_o);
          n_fail++;
        end
        if (last_of_group_o !== exp_byte.grp_last) begin
          $display("%0t: last_of_group expected %b got %b", $time,
                   exp_byte.grp_last, last_of_group_o);
          n_fail++;
        end
        if (last_of_stream_o !== exp_byte.strm_last) begin
          $display("%0t: last_of_stream expected %b got %b", $time,
                   exp_byte.strm_last, last_of_stream_o);
          n_fail++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles, %0d bytes still due", $time,
               StallLimit, pending_bytes.size());
      $display("tb_base64_stream_decoder_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, drain and final verdict
  initial begin
    grp_pos = '0;
    held_sextets = '0;
    third_pad = 1'b0;
    send_idx = 0;
    n_in = 0;
    n_fail = 0;
    quiet_cycles = 0;
    sender_idle_pct = 30;
    receiver_stall_pct = 45;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (n_in < n_items || pending_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("tb_base64_stream_decoder_core passed");
    end else begin
      $display("tb_base64_stream_decoder_core failed");
    end
    $finish;
  end

endmodule
